@@ rtl/tgdf_pkg.sv @@
// Shared types and constants for the thousands-grouped decimal formatter.
// No dependencies.
package tgdf_pkg;

  localparam int VALUE_W          = 64;
  localparam int CHAR_W           = 8;
  localparam int DEF_MAX_DIGITS   = 19;
  localparam int DEF_GROUP_SIZE   = 3;
  localparam int BIT_CNT_W        = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] SEP_RESET     = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_NONE     = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic count;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic next_last;
  } status_t;

endpackage

@@ rtl/tgdf_if.sv @@
// Handshake channel interfaces: input value, result character, separator write.
// Depends on tgdf_pkg.
interface tgdf_in_if;
  logic                          valid;
  logic                          ready;
  logic [tgdf_pkg::VALUE_W-1:0]  value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tgdf_out_if;
  logic                          valid;
  logic                          ready;
  logic [tgdf_pkg::CHAR_W-1:0]   char_code;
  logic                          too_large;
  logic                          last_char;
  modport source (output valid, output char_code, output too_large, output last_char,
                  input ready);
  modport sink   (input valid, input char_code, input too_large, input last_char,
                  output ready);
endinterface

interface tgdf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tgdf_pkg::CHAR_W-1:0]   separator_char;
  modport source (output valid, output separator_char, input ready);
  modport sink   (input valid, input separator_char, output ready);
endinterface

@@ rtl/tgdf_ctrl.sv @@
// Controller FSM: sequences load, 64 double-dabble shifts, digit count, emit.
// Depends on tgdf_pkg.
module tgdf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tgdf_pkg::status_t status,
  output tgdf_pkg::cmd_t    cmd
);

  tgdf_pkg::state_t                   state_r, state_nxt;
  logic [tgdf_pkg::BIT_CNT_W-1:0]     cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgdf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tgdf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = tgdf_pkg::ST_CONVERT;
        end
      end
      tgdf_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == {tgdf_pkg::BIT_CNT_W{1'b1}}) begin
          state_nxt = tgdf_pkg::ST_COUNT;
        end
      end
      tgdf_pkg::ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = tgdf_pkg::ST_EMIT;
      end
      tgdf_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.next_last) begin
            state_nxt = tgdf_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = tgdf_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/tgdf_dp.sv @@
// Datapath: bit-serial binary-to-BCD, leading digit encoder, character
// emitter with group separators, output register. Depends on tgdf_pkg.
module tgdf_dp #(
  parameter int MAX_DIGITS = tgdf_pkg::DEF_MAX_DIGITS,
  parameter int GROUP_SIZE = tgdf_pkg::DEF_GROUP_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tgdf_pkg::cmd_t                  cmd,
  output tgdf_pkg::status_t               status,
  input  logic [tgdf_pkg::VALUE_W-1:0]    value,
  input  logic                            cfg_we,
  input  logic [tgdf_pkg::CHAR_W-1:0]     cfg_sep,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tgdf_pkg::CHAR_W-1:0]     out_char_code,
  output logic                            out_too_large,
  output logic                            out_last_char
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int POS_W = $clog2(MAX_DIGITS);
  localparam int PH_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam logic [PH_W-1:0] PH_TOP = PH_W'(GROUP_SIZE - 1);

  logic [tgdf_pkg::VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]             bcd_r;
  logic [BCD_W-1:0]             bcd_fix;
  logic                         ovf_r;
  logic [POS_W-1:0]             pos_r;
  logic [PH_W-1:0]              phase_r;
  logic                         sep_pend_r;
  logic                         big_r;
  logic [tgdf_pkg::CHAR_W-1:0]  sep_r;
  logic                         out_valid_r;
  logic [tgdf_pkg::CHAR_W-1:0]  char_r;
  logic                         tl_r;
  logic                         last_r;

  logic [POS_W-1:0]             top_pos;
  logic [PH_W-1:0]              top_phase;
  logic [3:0]                   cur_digit;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_fix[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    top_pos   = '0;
    top_phase = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        top_pos   = POS_W'(i);
        top_phase = PH_W'(i % GROUP_SIZE);
      end
    end
  end

  assign cur_digit = bcd_r[{pos_r, 2'b00} +: 4];

  assign status.out_free  = !out_valid_r || out_ready;
  assign status.next_last = big_r || (!sep_pend_r && (pos_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= tgdf_pkg::SEP_RESET;
    end else if (cfg_we) begin
      sep_r <= cfg_sep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= value;
      bcd_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.shift) begin
      ovf_r <= ovf_r | bcd_fix[BCD_W-1];
      bcd_r <= {bcd_fix[BCD_W-2:0], bin_r[tgdf_pkg::VALUE_W-1]};
      bin_r <= {bin_r[tgdf_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_pend_r <= 1'b0;
      big_r      <= 1'b0;
      pos_r      <= '0;
      phase_r    <= '0;
    end else if (cmd.count) begin
      pos_r      <= top_pos;
      phase_r    <= top_phase;
      sep_pend_r <= 1'b0;
      big_r      <= ovf_r;
    end else if (cmd.emit && !big_r) begin
      if (sep_pend_r) begin
        sep_pend_r <= 1'b0;
      end else begin
        sep_pend_r <= (pos_r != '0) && (phase_r == '0);
        pos_r      <= pos_r - 1'b1;
        phase_r    <= (phase_r == '0) ? PH_TOP : phase_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      priority if (big_r) begin
        char_r <= tgdf_pkg::CHAR_NONE;
        tl_r   <= 1'b1;
        last_r <= 1'b1;
      end else if (sep_pend_r) begin
        char_r <= sep_r;
        tl_r   <= 1'b0;
        last_r <= 1'b0;
      end else begin
        char_r <= tgdf_pkg::ASCII_ZERO | {4'h0, cur_digit};
        tl_r   <= 1'b0;
        last_r <= (pos_r == '0);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_too_large = tl_r;
  assign out_last_char = last_r;

endmodule

@@ rtl/thousands_grouped_decimal_formatter.sv @@
// Thousands-grouped decimal formatter, top level.
// Each value is accepted, converted by the bit-serial BCD loop and its digits counted;
// then one character per cycle while the output is not stalled. A new value is taken
// only after the last character of the previous one has been emitted.
// Reset (rst_n, synchronous): FSM idle, output empty, separator back to ','.
// Depends on tgdf_pkg, tgdf_if, tgdf_ctrl, tgdf_dp.
module thousands_grouped_decimal_formatter #(
  parameter int MAX_DIGITS = tgdf_pkg::DEF_MAX_DIGITS,
  parameter int GROUP_SIZE = tgdf_pkg::DEF_GROUP_SIZE
) (
  input  logic          clk,
  input  logic          rst_n,
  tgdf_in_if.sink       in_ch,
  tgdf_out_if.source    out_ch,
  tgdf_cfg_if.sink      cfg_ch
);

  tgdf_pkg::cmd_t    cmd;
  tgdf_pkg::status_t status;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  tgdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tgdf_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .value         (in_ch.value),
    .cfg_we        (cfg_ch.valid),
    .cfg_sep       (cfg_ch.separator_char),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_too_large (out_ch.too_large),
    .out_last_char (out_ch.last_char)
  );

endmodule

@@ sim/tb_thousands_grouped_decimal_formatter.sv @@
// Self-checking testbench for thousands_grouped_decimal_formatter: directed values, then
// random values under several separator settings, with random input gaps and output stalls.
// Depends on tgdf_pkg, tgdf_if and the formatter RTL.
module tb_thousands_grouped_decimal_formatter;

  localparam int VALUE_W         = tgdf_pkg::VALUE_W;
  localparam int CHAR_W          = tgdf_pkg::CHAR_W;
  localparam int LIMIT_CYCLES    = 1000000;
  localparam int DIGITS_MAX      = tgdf_pkg::DEF_MAX_DIGITS;
  localparam int GROUP           = tgdf_pkg::DEF_GROUP_SIZE;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int NUM_DIR_ROWS    = 22;
  localparam logic [VALUE_W-1:0] TEN_POW_19 = 64'd10000000000000000000;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              too_large;
    logic              last_char;
  } char_item_t;

  // text empty and big clear: expectation comes from the predictor
  typedef struct {
    logic [VALUE_W-1:0] value;
    string              text;
    bit                 big;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycle_cnt = 0;
  int error_cnt = 0;
  bit in_steady = 1'b0;
  logic [CHAR_W-1:0] sep_now = tgdf_pkg::SEP_RESET;
  char_item_t expected_chars[$];
  dir_row_t dir_rows[NUM_DIR_ROWS];

  tgdf_in_if  in_bus();
  tgdf_out_if out_bus();
  tgdf_cfg_if cfg_bus();

  thousands_grouped_decimal_formatter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void predict_grouped(input logic [VALUE_W-1:0] v);
    logic [3:0] digs[20];
    logic [VALUE_W-1:0] r;
    int n;
    r = v;
    n = 0;
    do begin
      digs[n] = 4'(r % 64'd10);
      r = r / 64'd10;
      n++;
    end while (r != 0 && n < 20);
    if (n > DIGITS_MAX) begin
      expected_chars.push_back('{tgdf_pkg::CHAR_NONE, 1'b1, 1'b1});
      return;
    end
    for (int pos = n - 1; pos >= 0; pos--) begin
      expected_chars.push_back('{tgdf_pkg::ASCII_ZERO + CHAR_W'(digs[pos]), 1'b0, pos == 0});
      if (pos > 0 && pos % GROUP == 0) expected_chars.push_back('{sep_now, 1'b0, 1'b0});
    end
  endfunction

  function automatic void expect_text(input string s);
    for (int i = 0; i < s.len(); i++)
      expected_chars.push_back('{CHAR_W'(s[i]), 1'b0, i == s.len() - 1});
  endfunction

  // mix of full-width noise, 20-digit values and n-digit values rich in zero digits
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind < 2) return {$urandom, $urandom};
    if (kind == 2)
      return TEN_POW_19 + ({$urandom, $urandom} % (64'hFFFF_FFFF_FFFF_FFFF - TEN_POW_19 + 64'd1));
    n = $urandom_range(1, DIGITS_MAX);
    v = 64'($urandom_range(1, 9));
    for (int i = 1; i < n; i++)
      v = v * 64'd10 + 64'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
    return v;
  endfunction

  // called at a falling edge; returns at the rising edge that takes the item
  task automatic drive_value(input logic [VALUE_W-1:0] v);
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic input_gap();
    int gap;
    @(negedge clk);
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_separator(input logic [CHAR_W-1:0] s);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.separator_char <= s;
    do @(posedge clk); while (!cfg_bus.ready);
    sep_now = s;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int burst;
    int gap;
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      burst = $urandom_range(1, 30);
      out_bus.ready <= 1'b1;
      repeat (burst) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    char_item_t got;
    char_item_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.char_code, out_bus.too_large, out_bus.last_char};
      if (expected_chars.size() == 0) begin
        flag_error($sformatf("item with nothing expected: char %02h", got.char_code));
      end else begin
        want = expected_chars.pop_front();
        if (got.char_code !== want.char_code)
          flag_error($sformatf("char_code %02h, expected %02h", got.char_code, want.char_code));
        if (got.too_large !== want.too_large)
          flag_error($sformatf("too_large %b, expected %b", got.too_large, want.too_large));
        if (got.last_char !== want.last_char)
          flag_error($sformatf("last_char %b, expected %b", got.last_char, want.last_char));
      end
    end
  end

  initial begin
    logic [CHAR_W-1:0] sep_list[6];
    logic [VALUE_W-1:0] v;
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.value           = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.separator_char = '0;
    dir_rows = '{
      '{64'd0,                     "0",                         1'b0},
      '{64'd9,                     "9",                         1'b0},
      '{64'd10,                    "10",                        1'b0},
      '{64'd999,                   "999",                       1'b0},
      '{64'd1000,                  "1,000",                     1'b0},
      '{64'd1001,                  "1,001",                     1'b0},
      '{64'd12345,                 "12,345",                    1'b0},
      '{64'd100000,                "100,000",                   1'b0},
      '{64'd1000000,               "1,000,000",                 1'b0},
      '{64'd1002003,               "1,002,003",                 1'b0},
      '{64'd1000000000,            "1,000,000,000",             1'b0},
      '{64'd1000000000000,         "",                          1'b0},
      '{64'd1000000000000000,      "",                          1'b0},
      '{64'd1000000000000000000,   "1,000,000,000,000,000,000", 1'b0},
      '{64'd1000000000000000001,   "",                          1'b0},
      '{64'd9999999999999999999,   "9,999,999,999,999,999,999", 1'b0},
      '{64'd10000000000000000000,  "",                          1'b1},
      '{64'hFFFF_FFFF_FFFF_FFFF,   "",                          1'b1},
      '{64'h8000_0000_0000_0000,   "9,223,372,036,854,775,808", 1'b0},
      '{64'h0000_0000_FFFF_FFFF,   "",                          1'b0},
      '{64'h5555_5555_5555_5555,   "",                          1'b0},
      '{64'hAAAA_AAAA_AAAA_AAAA,   "",                          1'b1}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      drive_value(dir_rows[i].value);
      if (dir_rows[i].big) expected_chars.push_back('{tgdf_pkg::CHAR_NONE, 1'b1, 1'b1});
      else if (dir_rows[i].text.len() > 0) expect_text(dir_rows[i].text);
      else predict_grouped(dir_rows[i].value);
      input_gap();
    end
    drain();

    // extremes, two plain separators, a digit code and a random code
    sep_list = '{8'h00, 8'hFF, 8'h2E, 8'h30, 8'h5F, CHAR_W'($urandom)};
    for (int p = 0; p < 6; p++) begin
      write_separator(sep_list[p]);
      in_steady = (p == 2);
      repeat (ITEMS_PER_PHASE) begin
        v = rand_value();
        drive_value(v);
        predict_grouped(v);
        input_gap();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
